// ----- rtl/core/rrwl_pkg.sv -----
// Shared types and codes for the reentrant reader-writer lock unit.
// Holds the request and result payloads, the scan token and the update codes.
// No dependencies.
package rrwl_pkg;

  // Request commands.
  typedef enum logic [1:0] {
    CMD_TRY_EXCL   = 2'd0,
    CMD_TRY_SHARED = 2'd1,
    CMD_REL_EXCL   = 2'd2,
    CMD_REL_SHARED = 2'd3
  } cmd_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_GRANTED  = 3'd0,
    ST_BUSY     = 3'd1,
    ST_FULL     = 3'd2,
    ST_RELEASED = 3'd3,
    ST_NOTHING  = 3'd4,
    ST_UNKNOWN  = 3'd5,
    ST_LIMIT    = 3'd6
  } status_e;

  // Slot update broadcast to the cells at the end of a scan.
  typedef enum logic [1:0] {
    UPD_NONE  = 2'd0,
    UPD_ALLOC = 2'd1,
    UPD_INC   = 2'd2,
    UPD_DEC   = 2'd3
  } upd_e;

  // Sequencer states.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_e;

  // Request payload.
  typedef struct packed {
    cmd_e        command;
    logic [15:0] requester_id;
  } in_t;

  // Result payload.
  typedef struct packed {
    status_e     status;
    logic [15:0] total_holds;
    logic [15:0] exclusive_depth;
  } out_t;

  // Token that walks down the row of slot cells, one cell per cycle.
  typedef struct packed {
    logic valid;        // token present at this stage
    logic own_done;     // ownership test already decided upstream
    logic own_ok;       // decided result of the ownership test
    logic match_found;  // a slot owned by the requester was seen
    logic match_full;   // that slot's count is at its limit
    logic free_found;   // a free slot was seen
  } tok_t;

endpackage

// ----- rtl/core/reentrant_reader_writer_lock.sv -----
// Top level of the reentrant reader-writer lock unit.
// Holds the global counts, the request sequencer and the row of slot cells.
// Depends on rrwl_pkg and rrwl_cell.
//
// A request is taken when start is high and busy is low. Its scan token walks
// down the row of SLOTS slot cells, one cell per clock, and the decision and
// slot update happen in the cycle the token leaves the last cell. The result
// appears on out_res with out_valid high for exactly one cycle and must be
// taken then: the receiver cannot stall it. busy drops in that same cycle, so
// the next request may be accepted while the result shows.
module reentrant_reader_writer_lock #(
  parameter int SLOTS      = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  rrwl_pkg::in_t in_req,
  output logic          out_valid,
  output rrwl_pkg::out_t out_res
);
  import rrwl_pkg::*;

  localparam logic [COUNT_BITS-1:0] CntMax = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CntOne = {{(COUNT_BITS-1){1'b0}}, 1'b1};

  state_e                state_r, state_nxt;
  cmd_e                  cmd_r;
  logic [15:0]           id_r;
  logic [COUNT_BITS-1:0] total_r, total_nxt;
  logic [COUNT_BITS-1:0] exc_r, exc_nxt;
  tok_t                  tok_r, tok_nxt;
  logic                  out_valid_r;
  out_t                  out_res_r;

  logic                  accept, done, own_ok, at_limit;
  upd_e                  upd;
  status_e               status;
  tok_t                  tok [SLOTS+1];
  logic [COUNT_BITS+15:0] total_ext, exc_ext;

  assign accept = start && !busy;
  assign done   = tok[SLOTS].valid;

  // Fresh token for an accepted request.
  always_comb begin
    tok_nxt       = '0;
    tok_nxt.valid = accept;
  end

  // Row of slot cells; the token enters from tok_r.
  assign tok[0] = tok_r;
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    rrwl_cell #(
      .COUNT_BITS(COUNT_BITS)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .clr    (accept),
      .req_id (id_r),
      .total  (total_r),
      .upd    (upd),
      .tok_in (tok[i]),
      .tok_out(tok[i+1])
    );
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output logic of the sequencer.
  always_comb begin
    case (state_r)
      S_IDLE:  busy = 1'b0;
      default: busy = 1'b1;
    endcase
  end

  // Decision once the scan is complete.
  assign own_ok   = (total_r == '0) || !tok[SLOTS].own_done || tok[SLOTS].own_ok;
  assign at_limit = (total_r == CntMax) || (exc_r == CntMax);

  always_comb begin
    status    = ST_BUSY;
    upd       = UPD_NONE;
    total_nxt = total_r;
    exc_nxt   = exc_r;
    if (done) begin
      if (id_r == 16'd0) begin
        status = (cmd_r inside {CMD_TRY_EXCL, CMD_TRY_SHARED}) ? ST_BUSY : ST_NOTHING;
      end else begin
        case (cmd_r)
          CMD_TRY_EXCL, CMD_TRY_SHARED: begin
            if (!(own_ok || (cmd_r == CMD_TRY_SHARED && exc_r == '0))) begin
              status = ST_BUSY;
            end else if (!tok[SLOTS].match_found && !tok[SLOTS].free_found) begin
              status = ST_FULL;
            end else if (at_limit ||
                         (tok[SLOTS].match_found && tok[SLOTS].match_full)) begin
              status = ST_LIMIT;
            end else begin
              status    = ST_GRANTED;
              upd       = tok[SLOTS].match_found ? UPD_INC : UPD_ALLOC;
              total_nxt = total_r + CntOne;
              if (exc_r != '0) begin
                exc_nxt = exc_r + CntOne;
              end else if (cmd_r == CMD_TRY_EXCL) begin
                exc_nxt = CntOne;
              end
            end
          end
          default: begin
            if (total_r == '0) begin
              status = ST_NOTHING;
            end else begin
              total_nxt = total_r - CntOne;
              if (cmd_r == CMD_REL_EXCL && exc_r != '0) begin
                exc_nxt = exc_r - CntOne;
              end
              if (tok[SLOTS].match_found) begin
                status = ST_RELEASED;
                upd    = UPD_DEC;
              end else begin
                status = ST_UNKNOWN;
              end
            end
          end
        endcase
      end
    end
  end

  // Counts go out at sixteen bits.
  assign total_ext = {16'd0, total_nxt};
  assign exc_ext   = {16'd0, exc_nxt};

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tok_r       <= '0;
      out_valid_r <= 1'b0;
      total_r     <= '0;
      exc_r       <= '0;
    end else begin
      state_r       <= state_nxt;
      tok_r         <= tok_nxt;
      out_valid_r   <= done;
      total_r       <= total_nxt;
      exc_r         <= exc_nxt;
    end
  end

  // Request capture and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_req.command;
      id_r  <= in_req.requester_id;
    end
    if (done) begin
      out_res_r.status          <= status;
      out_res_r.total_holds     <= total_ext[15:0];
      out_res_r.exclusive_depth <= exc_ext[15:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

`ifndef NO_ASSERTIONS
  // Every result follows the token leaving the last cell.
  a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(done))
    else $error("result without a finished scan");
  // A scan only finishes while the sequencer is working.
  a_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> (state_r == S_SCAN))
    else $error("token finished outside a scan");
  // An accepted request keeps the unit busy next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy && !out_valid))
    else $error("accepted request not held busy");
  // Results never come in consecutive cycles.
  a_result_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");
`endif

endmodule

// ----- rtl/core/rrwl_cell.sv -----
// One slot cell of the lock unit: holds a slot owner and count.
// Examines the passing scan token and applies the broadcast update.
// Depends on rrwl_pkg.
module rrwl_cell #(
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  clr,
  input  logic [15:0]           req_id,
  input  logic [COUNT_BITS-1:0] total,
  input  rrwl_pkg::upd_e        upd,
  input  rrwl_pkg::tok_t        tok_in,
  output rrwl_pkg::tok_t        tok_out
);
  import rrwl_pkg::*;

  localparam logic [COUNT_BITS-1:0] CntMax = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CntOne = {{(COUNT_BITS-1){1'b0}}, 1'b1};

  logic [15:0]           owner_r;
  logic [COUNT_BITS-1:0] count_r;
  logic                  sel_match_r, sel_match_nxt;
  logic                  sel_free_r, sel_free_nxt;
  tok_t                  tok_r, tok_nxt;

  logic is_match, is_free, own_other, own_self;

  // Local view of this slot against the request.
  assign is_match  = (owner_r == req_id);
  assign is_free   = (owner_r == 16'd0);
  assign own_other = !is_match && (count_r != '0);
  assign own_self  = is_match && (count_r == total);

  // Token update and first-hit selection as the token passes.
  always_comb begin
    tok_nxt       = tok_in;
    sel_match_nxt = sel_match_r;
    sel_free_nxt  = sel_free_r;
    if (clr) begin
      sel_match_nxt = 1'b0;
      sel_free_nxt  = 1'b0;
    end else if (tok_in.valid) begin
      if (!tok_in.own_done) begin
        tok_nxt.own_done = own_other || own_self;
        tok_nxt.own_ok   = own_self;
      end
      if (!tok_in.match_found && is_match) begin
        tok_nxt.match_found = 1'b1;
        tok_nxt.match_full  = (count_r == CntMax);
        sel_match_nxt       = 1'b1;
      end
      if (!tok_in.free_found && is_free) begin
        tok_nxt.free_found = 1'b1;
        sel_free_nxt       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r       <= '0;
      sel_match_r <= 1'b0;
      sel_free_r  <= 1'b0;
    end else begin
      tok_r       <= tok_nxt;
      sel_match_r <= sel_match_nxt;
      sel_free_r  <= sel_free_nxt;
    end
  end

  // Slot contents change only under the broadcast update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owner_r <= '0;
      count_r <= '0;
    end else begin
      case (upd)
        UPD_ALLOC: begin
          if (sel_free_r) begin
            owner_r <= req_id;
            count_r <= CntOne;
          end
        end
        UPD_INC: begin
          if (sel_match_r) begin
            count_r <= count_r + CntOne;
          end
        end
        UPD_DEC: begin
          if (sel_match_r) begin
            if (count_r != '0) begin
              count_r <= count_r - CntOne;
            end
            if (count_r <= CntOne) begin
              owner_r <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign tok_out = tok_r;

`ifndef NO_ASSERTIONS
  // A token leaves this cell in the cycle after it arrived.
  a_tok_shift: assert property (@(posedge clk) disable iff (!rst_n)
    tok_in.valid |=> tok_out.valid)
    else $error("token lost in cell");
  // Selections are only made while a token is passing.
  a_sel_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(sel_match_r) |-> $past(tok_in.valid))
    else $error("slot selected without a token");
  // A slot is freed only under a release update.
  a_free_on_dec: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(owner_r) != 16'd0 && owner_r == 16'd0) |-> $past(upd == UPD_DEC))
    else $error("slot freed without a release");
`endif

endmodule

// ----- bench/tb_reentrant_reader_writer_lock.sv -----
// Self-checking bench for the reentrant reader-writer lock unit.
// Drives lock requests, predicts every reply from a private copy of the lock state.
// Depends on rrwl_pkg and reentrant_reader_writer_lock.
module tb_reentrant_reader_writer_lock;
  timeunit 1ns;
  timeprecision 1ps;

  import rrwl_pkg::*;

  localparam int SLOTS            = 16;
  localparam int COUNT_BITS       = 16;
  localparam int RANDOM_PER_PHASE = 660;
  localparam int POOL             = 20;
  localparam int WATCHDOG         = 1000;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_req = '0;
  logic out_valid;
  out_t out_res;

  reentrant_reader_writer_lock #(
    .SLOTS(SLOTS),
    .COUNT_BITS(COUNT_BITS)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_req(in_req),
    .out_valid(out_valid),
    .out_res(out_res)
  );

  // Shadow of the lock state, updated as each request is accepted.
  logic [COUNT_BITS-1:0] hold_total = '0;
  logic [COUNT_BITS-1:0] excl_depth = '0;
  logic [15:0]           slot_id  [SLOTS] = '{default: '0};
  logic [COUNT_BITS-1:0] slot_cnt [SLOTS] = '{default: '0};

  in_t  request_queue [$];
  out_t replies_due [$];
  logic [15:0] id_pool [POOL];
  int   issued_cnt = 0;
  int   accepted_cnt = 0;
  int   fault_count = 0;
  int   quiet_cycles = 0;
  int   gap_pct = 0;
  int   release_pct = 45;
  int   status_tally [0:7] = '{default: 0};
  logic taken = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int slot_of(logic [15:0] id);
    for (int i = 0; i < SLOTS; i++)
      if (slot_id[i] == id) return i;
    return -1;
  endfunction

  // The requester holds every count that is held, as seen by a scan from slot zero.
  function automatic logic sole_holder(logic [15:0] id);
    if (hold_total == 0) return 1'b1;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_id[i] != id && slot_cnt[i] != 0) return 1'b0;
      if (slot_id[i] == id && slot_cnt[i] == hold_total) return 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic status_e grant_lock(logic [15:0] id, logic excl);
    int  s;
    logic ok;
    ok = excl ? sole_holder(id) : (excl_depth == 0 || sole_holder(id));
    if (!ok) return ST_BUSY;
    s = slot_of(id);
    if (s < 0) begin
      s = slot_of(16'd0);
      if (s < 0) return ST_FULL;
      if (hold_total == CNT_MAX || excl_depth == CNT_MAX) return ST_LIMIT;
      slot_id[s]  = id;
      slot_cnt[s] = CNT_ONE;
    end else begin
      if (hold_total == CNT_MAX || excl_depth == CNT_MAX || slot_cnt[s] == CNT_MAX)
        return ST_LIMIT;
      slot_cnt[s] = slot_cnt[s] + CNT_ONE;
    end
    hold_total = hold_total + CNT_ONE;
    if (excl_depth != 0) excl_depth = excl_depth + CNT_ONE;
    else if (excl) excl_depth = CNT_ONE;
    return ST_GRANTED;
  endfunction

  function automatic status_e release_lock(logic [15:0] id, logic excl);
    int s;
    if (hold_total == 0) return ST_NOTHING;
    hold_total = hold_total - CNT_ONE;
    if (excl && excl_depth != 0) excl_depth = excl_depth - CNT_ONE;
    s = slot_of(id);
    if (s < 0) return ST_UNKNOWN;
    if (slot_cnt[s] != 0) slot_cnt[s] = slot_cnt[s] - CNT_ONE;
    if (slot_cnt[s] == 0) slot_id[s] = '0;
    return ST_RELEASED;
  endfunction

  // Expected reply to one accepted request; updates the shadow state.
  function automatic out_t predict_lock_reply(in_t r);
    out_t o;
    if (r.requester_id == 0) begin
      o.status = (r.command == CMD_TRY_EXCL || r.command == CMD_TRY_SHARED) ?
                 ST_BUSY : ST_NOTHING;
    end else begin
      case (r.command)
        CMD_TRY_EXCL:   o.status = grant_lock(r.requester_id, 1'b1);
        CMD_TRY_SHARED: o.status = grant_lock(r.requester_id, 1'b0);
        CMD_REL_EXCL:   o.status = release_lock(r.requester_id, 1'b1);
        default:        o.status = release_lock(r.requester_id, 1'b0);
      endcase
    end
    o.total_holds     = hold_total[15:0];
    o.exclusive_depth = excl_depth[15:0];
    return o;
  endfunction

  function automatic logic [15:0] unused_id(logic [15:0] base);
    logic [15:0] id;
    id = base;
    while (id == 0 || slot_of(id) >= 0) id++;
    return id;
  endfunction

  // Next contention request, chosen from the current lock state. Releases come
  // from real holders, and exclusive releases are used while the depth is
  // nonzero so the depth never outlives the holds. A few requests are noise.
  function automatic in_t pick_request();
    in_t r;
    int  held [$];
    int  k;
    for (int i = 0; i < SLOTS; i++)
      if (slot_id[i] != 0 && slot_cnt[i] != 0) held.push_back(i);
    r.requester_id = id_pool[$urandom_range(POOL - 1)];
    r.command = ($urandom_range(3) == 0) ? CMD_TRY_EXCL : CMD_TRY_SHARED;
    if ($urandom_range(99) < 8) begin
      r.command = cmd_e'($urandom_range(3));
      r.requester_id = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom);
      if ((r.command == CMD_REL_EXCL || r.command == CMD_REL_SHARED) && hold_total != 0) begin
        if ($urandom_range(3) != 0) r.command = CMD_TRY_SHARED;
        else if (excl_depth != 0) r.command = CMD_REL_EXCL;
      end
    end else if (held.size() != 0 && hold_total != 0 && $urandom_range(99) < release_pct) begin
      k = held[$urandom_range(held.size() - 1)];
      r.requester_id = slot_id[k];
      r.command = (excl_depth != 0) ? CMD_REL_EXCL : CMD_REL_SHARED;
    end
    return r;
  endfunction

  task automatic issue(input cmd_e c, input logic [15:0] id);
    in_t r;
    r.command      = c;
    r.requester_id = id;
    request_queue.push_back(r);
    issued_cnt++;
  endtask

  task automatic wait_accepted();
    while (accepted_cnt != issued_cnt) @(negedge clk);
  endtask

  // Request driver: presents queued requests at the falling edge, with random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || taken) begin
      if (request_queue.size() != 0 && $urandom_range(99) >= gap_pct) begin
        in_req <= request_queue.pop_front();
        start  <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: checks each reply, predicts each accepted request, runs the watchdog.
  always @(posedge clk) begin : monitor
    out_t want;
    taken <= rst_n && start && !busy;
    if (rst_n) begin
      if (out_valid) begin
        status_tally[out_res.status]++;
        if (replies_due.size() == 0) begin
          $error("reply with no request outstanding: status %0d", out_res.status);
          fault_count++;
        end else begin
          want = replies_due.pop_front();
          if (out_res.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_res.status);
            fault_count++;
          end
          if (out_res.total_holds !== want.total_holds) begin
            $error("total_holds: expected %0d, got %0d", want.total_holds,
                   out_res.total_holds);
            fault_count++;
          end
          if (out_res.exclusive_depth !== want.exclusive_depth) begin
            $error("exclusive_depth: expected %0d, got %0d", want.exclusive_depth,
                   out_res.exclusive_depth);
            fault_count++;
          end
        end
      end
      if (start && !busy) begin
        replies_due.push_back(predict_lock_reply(in_req));
        accepted_cnt++;
      end
      if (out_valid || (start && !busy)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Stimulus: directed cases, three pacing phases of contention, then a full-table run.
  initial begin
    in_t         r;
    int          k;
    int          free_cnt;
    logic [15:0] holder;
    logic [15:0] other;

    id_pool[0] = 16'hFFFF;
    id_pool[1] = 16'h0001;
    for (int i = 2; i < POOL; i++) id_pool[i] = 16'($urandom_range(1, 16'hEFFF));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reserved id, nothing held, sharing, upgrade, nesting, unknown release.
    gap_pct = 19;
    issue(CMD_REL_SHARED, 16'h0005);
    issue(CMD_REL_EXCL,   16'h0000);
    issue(CMD_TRY_EXCL,   16'h0000);
    issue(CMD_TRY_SHARED, 16'h0000);
    issue(CMD_TRY_SHARED, 16'hAAAA);
    issue(CMD_TRY_SHARED, 16'h5555);
    issue(CMD_TRY_EXCL,   16'hAAAA);
    issue(CMD_REL_SHARED, 16'hAAAA);
    issue(CMD_TRY_EXCL,   16'h5555);
    issue(CMD_TRY_EXCL,   16'h5555);
    issue(CMD_TRY_SHARED, 16'h5555);
    issue(CMD_TRY_SHARED, 16'hFFFF);
    issue(CMD_TRY_EXCL,   16'h0001);
    repeat (4) issue(CMD_REL_EXCL, 16'h5555);
    issue(CMD_REL_EXCL,   16'h1234);
    issue(CMD_TRY_EXCL,   16'hFFFF);
    issue(CMD_REL_EXCL,   16'h8001);
    issue(CMD_TRY_SHARED, 16'h0001);
    issue(CMD_REL_SHARED, 16'hFFFF);
    issue(CMD_REL_SHARED, 16'h0001);

    // Contention traffic, each request chosen once the previous one is in.
    for (int p = 0; p < 3; p++) begin
      gap_pct = (p == 0) ? 19 : (p == 1) ? 50 : 0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (n % 100 == 0) begin
          case ($urandom_range(2))
            0:       release_pct = 25;
            1:       release_pct = 45;
            default: release_pct = 60;
          endcase
        end
        wait_accepted();
        r = pick_request();
        issue(r.command, r.requester_id);
      end
    end

    // Drop every hold so the full-table run starts with no counts held.
    wait_accepted();
    while (hold_total != 0) begin
      k = -1;
      for (int i = SLOTS - 1; i >= 0; i--)
        if (slot_id[i] != 0 && slot_cnt[i] != 0) k = i;
      if (k >= 0) issue((excl_depth != 0) ? CMD_REL_EXCL : CMD_REL_SHARED, slot_id[k]);
      else issue(CMD_REL_EXCL, unused_id(16'hF000));
      wait_accepted();
    end

    // Fill the table with shared holders; the last one takes the last free slot.
    free_cnt = 0;
    for (int i = 0; i < SLOTS; i++)
      if (slot_id[i] == 0) free_cnt++;
    if (free_cnt != 0) begin
      for (int i = 0; i < free_cnt - 1; i++) begin
        issue(CMD_TRY_SHARED, unused_id(16'hF000));
        wait_accepted();
      end
      holder = unused_id(16'hF000);
      issue(CMD_TRY_SHARED, holder);
      wait_accepted();
      // A newcomer finds the table full; an upgrade is busy while others hold.
      other = unused_id(16'hF000);
      issue(CMD_TRY_SHARED, other);
      issue(CMD_TRY_SHARED, holder);
      issue(CMD_TRY_EXCL,   holder);
      wait_accepted();
      k = -1;
      for (int i = SLOTS - 1; i >= 0; i--)
        if (slot_id[i] != 0 && slot_id[i] != holder && slot_cnt[i] != 0) k = i;
      if (k >= 0) issue(CMD_REL_SHARED, slot_id[k]);
      issue(CMD_TRY_SHARED, holder);
      issue(CMD_TRY_SHARED, other);
      issue(CMD_TRY_EXCL,   other);
    end

    // Drain, then give stray replies time to show.
    gap_pct = 0;
    while (accepted_cnt != issued_cnt || replies_due.size() != 0) @(negedge clk);
    repeat (3 * SLOTS) @(negedge clk);

    $display("Checked %0d lock requests: directed cases, contention at three pacings,",
             accepted_cnt);
    $display({"and a full slot table; granted %0d, busy %0d, full %0d, released %0d, ",
              "nothing %0d, unknown %0d, limit %0d."},
             status_tally[ST_GRANTED], status_tally[ST_BUSY], status_tally[ST_FULL],
             status_tally[ST_RELEASED], status_tally[ST_NOTHING],
             status_tally[ST_UNKNOWN], status_tally[ST_LIMIT]);
    if (fault_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
